// ===== design/fcfla_pkg.sv =====
// ----------------------------------------------------------------------------
// fcfla_pkg
// Shared codes and field types for the fixed chunk free list allocator.
// ----------------------------------------------------------------------------
package fcfla_pkg;

   localparam int OPCODE_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int SHIFT_W    = 5;
   localparam int COUNT_W    = 11;

   typedef logic [OPCODE_W-1:0]   opcode_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [SHIFT_W-1:0]    shift_type;
   typedef logic [COUNT_W-1:0]    count_type;

   localparam opcode_type OP_ALLOC    = 2'd0;
   localparam opcode_type OP_FREE     = 2'd1;
   localparam opcode_type OP_FREE_ALL = 2'd2;

   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_EMPTY  = 2'd1;
   localparam status_type STATUS_NULL   = 2'd2;
   localparam status_type STATUS_RANGE  = 2'd3;

   localparam csr_index_type CSR_POOL_BASE   = 2'd0;
   localparam csr_index_type CSR_CHUNK_SHIFT = 2'd1;
   localparam csr_index_type CSR_CHUNK_COUNT = 2'd2;

   localparam logic [CSR_DATA_W-1:0] POOL_BASE_RESET   = 32'd4096;
   localparam shift_type             CHUNK_SHIFT_RESET = 5'd6;
   localparam count_type             CHUNK_COUNT_RESET = 11'd1024;

endpackage

// ===== design/fcfla_ram.sv =====
// ----------------------------------------------------------------------------
// fcfla_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fixed_chunk_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator_unit
// LIFO free list allocator over a pool of equal power-of-two sized chunks.
// ----------------------------------------------------------------------------
// Chunks are handed out and taken back as a last-in-first-out list whose
// links live in a one-port-write, one-port-read RAM of MAX_CHUNKS entries.
// One request is in flight at a time. Allocate reads the head's link from
// RAM, then replies; free registers the base subtract, then does the shift,
// range check and link write, and a free with a null or bad address takes the
// same path. Free-all rebuilds the list with one RAM write per chunk over
// chunk_count (saturated to MAX_CHUNKS) chunks. After reset the same walk
// runs over min(1024, MAX_CHUNKS) chunks, during which no item is accepted. A
// result waiting on rsp_tready does not block acceptance of the next request,
// but that request then holds until the result register frees up. chunk_count
// takes effect at the next free-all; pool_base and chunk_shift at once.
module fixed_chunk_free_list_allocator_unit #(
   parameter int MAX_CHUNKS = 1024,
   parameter int ADDR_BITS  = 32,
   localparam int IDX_W = $clog2(MAX_CHUNKS),
   localparam int REQ_W = ((fcfla_pkg::OPCODE_W + ADDR_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((fcfla_pkg::STATUS_W + ADDR_BITS + IDX_W + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_W-1:0]         req_tdata,   // opcode, address
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_W-1:0]         rsp_tdata,   // status, chunk_address, chunk_index
   input  logic                     csr_wr_en,
   input  fcfla_pkg::csr_index_type csr_index,
   input  fcfla_pkg::csr_data_type  csr_wdata
);

   import fcfla_pkg::*;

   localparam int LINK_W      = IDX_W + 1;
   localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);
   localparam int RESET_COUNT = (MAX_CHUNKS < 1024) ? MAX_CHUNKS : 1024;
   localparam int PAD_W       = RSP_W - STATUS_W - ADDR_BITS - IDX_W;

   localparam logic [LINK_W-1:0] LINK_EMPTY = {1'b1, {IDX_W{1'b0}}};

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ALLOC   = 3'd1;
   localparam logic [2:0] ST_FREE    = 3'd2;
   localparam logic [2:0] ST_DONE    = 3'd3;
   localparam logic [2:0] ST_REBUILD = 3'd4;

   // configuration
   logic [ADDR_BITS-1:0] pool_base_ff;
   shift_type            chunk_shift_ff;
   count_type            chunk_count_ff;

   // control
   logic [2:0]        state_ff,  state_in;
   logic [LINK_W-1:0] head_ff,   head_in;
   logic [CNT_W-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]  cnt_ff,    cnt_in;
   logic              reply_ff,  reply_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;

   // payload
   logic [ADDR_BITS-1:0] diff_ff,   diff_in;
   logic                 null_ff,   null_in;
   logic                 below_ff,  below_in;
   status_type           done_status_ff, done_status_in;
   status_type           rsp_status_ff,  rsp_status_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff,    rsp_addr_in;
   logic [IDX_W-1:0]     rsp_index_ff,   rsp_index_in;

   // link RAM
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [LINK_W-1:0] ram_wdata;
   logic              ram_re;
   logic [LINK_W-1:0] ram_rdata;

   opcode_type           req_opcode;
   logic [ADDR_BITS-1:0] req_address;
   logic                 slot_free;
   logic [CNT_W-1:0]     sat_count;
   logic [ADDR_BITS-1:0] free_idx_wide;
   logic                 out_range;
   logic [ADDR_BITS-1:0] alloc_addr;

   assign req_opcode  = req_tdata[OPCODE_W-1:0];
   assign req_address = req_tdata[OPCODE_W +: ADDR_BITS];

   fcfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_CHUNKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= ADDR_BITS'(POOL_BASE_RESET);
         chunk_shift_ff <= CHUNK_SHIFT_RESET;
         chunk_count_ff <= CHUNK_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POOL_BASE:   pool_base_ff   <= ADDR_BITS'(csr_wdata);
            CSR_CHUNK_SHIFT: chunk_shift_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_CHUNK_COUNT: chunk_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign slot_free     = !rsp_tvalid_ff || rsp_tready;
   assign sat_count     = (32'(chunk_count_ff) > 32'(MAX_CHUNKS)) ?
                          CNT_W'(MAX_CHUNKS) : CNT_W'(chunk_count_ff);
   assign free_idx_wide = diff_ff >> chunk_shift_ff;
   assign out_range     = below_ff ||
                          ({{CNT_W{1'b0}}, free_idx_wide} >= {{ADDR_BITS{1'b0}}, active_ff});
   assign alloc_addr    = pool_base_ff + (ADDR_BITS'(head_ff[IDX_W-1:0]) << chunk_shift_ff);
   assign req_tready    = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      active_in      = active_ff;
      cnt_in         = cnt_ff;
      reply_in       = reply_ff;
      diff_in        = diff_ff;
      null_in        = null_ff;
      below_in       = below_ff;
      done_status_in = done_status_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_index_in   = rsp_index_ff;
      ram_we         = 1'b0;
      ram_waddr      = '0;
      ram_wdata      = '0;
      ram_re         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_opcode)
                  OP_ALLOC: begin
                     if (head_ff[IDX_W]) begin
                        done_status_in = STATUS_EMPTY;
                        state_in       = ST_DONE;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = ST_ALLOC;
                     end
                  end
                  OP_FREE: begin
                     null_in  = (req_address == '0);
                     below_in = (req_address < pool_base_ff);
                     diff_in  = req_address - pool_base_ff;
                     state_in = ST_FREE;
                  end
                  OP_FREE_ALL: begin
                     head_in   = LINK_EMPTY;
                     cnt_in    = '0;
                     active_in = sat_count;
                     reply_in  = 1'b1;
                     state_in  = ST_REBUILD;
                  end
                  default: begin
                     done_status_in = STATUS_OK;
                     state_in       = ST_DONE;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_addr_in   = alloc_addr;
               rsp_index_in  = head_ff[IDX_W-1:0];
               head_in       = ram_rdata;
               state_in      = ST_IDLE;
            end
         end
         ST_FREE: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_addr_in   = '0;
               rsp_index_in  = '0;
               if (null_ff) begin
                  rsp_status_in = STATUS_NULL;
               end else if (out_range) begin
                  rsp_status_in = STATUS_RANGE;
               end else begin
                  ram_we        = 1'b1;
                  ram_waddr     = free_idx_wide[IDX_W-1:0];
                  ram_wdata     = head_ff;
                  head_in       = {1'b0, free_idx_wide[IDX_W-1:0]};
                  rsp_status_in = STATUS_OK;
                  rsp_index_in  = free_idx_wide[IDX_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = done_status_ff;
               rsp_addr_in   = '0;
               rsp_index_in  = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_REBUILD: begin
            if (cnt_ff == active_ff) begin
               if (reply_ff) begin
                  done_status_in = STATUS_OK;
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               ram_we    = 1'b1;
               ram_waddr = cnt_ff[IDX_W-1:0];
               ram_wdata = head_ff;
               head_in   = {1'b0, cnt_ff[IDX_W-1:0]};
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_REBUILD;
         head_ff       <= LINK_EMPTY;
         active_ff     <= CNT_W'(RESET_COUNT);
         cnt_ff        <= '0;
         reply_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         active_ff     <= active_in;
         cnt_ff        <= cnt_in;
         reply_ff      <= reply_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff        <= diff_in;
      null_ff        <= null_in;
      below_ff       <= below_in;
      done_status_ff <= done_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_index_ff, rsp_addr_ff, rsp_status_ff};

   // pop only from a non-empty list
   a_alloc_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |-> !head_ff[IDX_W])
      else $error("allocate pending with empty head");

   // head always names a chunk of the active pool
   a_head_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !head_ff[IDX_W]) |->
      (CNT_W'(head_ff[IDX_W-1:0]) < active_ff))
      else $error("head outside active pool");

   // results come only out of a work state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) != ST_IDLE && $past(state_ff) != ST_REBUILD))
      else $error("result produced without a request in progress");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the fixed chunk free list allocator.
// Drives allocate, free, free-all and unused-opcode requests over the req
// stream, with register writes between phases. A scoreboard class keeps its
// own copy of the free list and checks every rsp item in order. Sender gaps
// and receiver stalls vary by phase, and one long receiver hold-off backs
// the block up.
// ----------------------------------------------------------------------------
module tb;
   import fcfla_pkg::*;

   localparam int          MAX_CHUNKS = 1024;
   localparam logic [10:0] LIST_END   = 11'd1024;
   localparam opcode_type  OP_UNUSED  = 2'd3;
   localparam int          LIMIT      = 1000000;
   localparam int          PHASE_ITEMS = 172;

   typedef struct packed {
      status_type  status;
      logic [31:0] chunk_address;
      logic [9:0]  chunk_index;
   } alloc_result_type;

   class alloc_scoreboard;
      logic [31:0]      base;
      shift_type        shift;
      count_type        count;
      logic [10:0]      head;
      logic [10:0]      link [MAX_CHUNKS];
      int unsigned      active;
      alloc_result_type expected [$];
      int unsigned      held [$];
      int               errors;

      function void power_on();
         base   = POOL_BASE_RESET;
         shift  = CHUNK_SHIFT_RESET;
         count  = CHUNK_COUNT_RESET;
         errors = 0;
         foreach (link[i]) link[i] = LIST_END;
         rebuild();
      endfunction

      function void rebuild();
         int unsigned n;
         int unsigned i;
         n = (count > MAX_CHUNKS) ? MAX_CHUNKS : count;
         active = n;
         head = LIST_END;
         held.delete();
         for (i = 0; i < n; i++) begin
            link[i] = head;
            head = i[10:0];
         end
      endfunction

      function void write_reg(csr_index_type idx, csr_data_type value);
         case (idx)
            CSR_POOL_BASE:   base  = value;
            CSR_CHUNK_SHIFT: shift = value[SHIFT_W-1:0];
            CSR_CHUNK_COUNT: count = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(opcode_type op, logic [31:0] addr);
         alloc_result_type r;
         logic [63:0]      sum;
         logic [63:0]      offset;
         logic [10:0]      top;
         r = '0;
         case (op)
            OP_ALLOC: begin
               if (head >= LIST_END) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  top = head;
                  head = link[top];
                  sum = {32'd0, base} + ({53'd0, top} << shift);
                  r.chunk_address = sum[31:0];
                  r.chunk_index = top[9:0];
                  held.push_back(top);
               end
            end
            OP_FREE: begin
               if (addr == 32'd0) begin
                  r.status = STATUS_NULL;
               end else if (addr < base) begin
                  r.status = STATUS_RANGE;
               end else begin
                  offset = ({32'd0, addr} - {32'd0, base}) >> shift;
                  if (offset >= active || offset >= MAX_CHUNKS) begin
                     r.status = STATUS_RANGE;
                  end else begin
                     link[offset[9:0]] = head;
                     head = offset[10:0];
                     r.chunk_index = offset[9:0];
                  end
               end
            end
            OP_FREE_ALL: rebuild();
            default: ;
         endcase
         expected.push_back(r);
      endfunction

      function void check_result(logic [47:0] data);
         alloc_result_type want;
         if (expected.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("tb: unexpected rsp item %h", data);
            return;
         end
         want = expected.pop_front();
         if (data[1:0] !== want.status || data[33:2] !== want.chunk_address ||
             data[43:34] !== want.chunk_index) begin
            errors++;
            if (errors <= 10)
               $display("tb: mismatch status %0d/%0d address %h/%h index %0d/%0d",
                        want.status, data[1:0], want.chunk_address, data[33:2],
                        want.chunk_index, data[43:34]);
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [39:0]   req_tdata;    // opcode, address
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [47:0]   rsp_tdata;    // status, chunk_address, chunk_index
   logic          csr_wr_en;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   alloc_scoreboard sb;
   int  src_idle_pct;
   int  dst_stall_pct;
   bit  hold_go;
   bit  rsp_hold;
   int  cycle_count;

   fixed_chunk_free_list_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // long receiver hold-off, started once by the stimulus
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go);
      rsp_hold = 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= dst_stall_pct);
   end

   task automatic send_item(input opcode_type op, input logic [31:0] addr);
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, addr, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, addr);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input csr_data_type value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // new settings, then free-all so the count takes effect
   task automatic configure(input logic [31:0] base, input csr_data_type shift,
                            input csr_data_type count);
      drain();
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_CHUNK_SHIFT, shift);
      write_csr(CSR_CHUNK_COUNT, count);
      csr_wr_en <= 1'b0;
      send_item(OP_FREE_ALL, $urandom);
   endtask

   function automatic logic [31:0] chunk_addr(input int unsigned idx);
      logic [63:0] sum;
      logic [63:0] low;
      low = ((64'd1 << sb.shift) - 64'd1) & {32'd0, $urandom};
      sum = {32'd0, sb.base} + ({32'd0, idx} << sb.shift) + low;
      return sum[31:0];
   endfunction

   task automatic random_item();
      int unsigned r;
      int unsigned pick;
      int unsigned idx;
      logic [31:0] addr;
      r = $urandom_range(99);
      addr = $urandom;
      if (r < 42 || (r < 72 && sb.held.size() == 0)) begin
         send_item(OP_ALLOC, addr);
      end else if (r < 72) begin
         pick = $urandom_range(sb.held.size() - 1);
         idx = sb.held[pick];
         sb.held.delete(pick);
         send_item(OP_FREE, chunk_addr(idx));
      end else if (r < 78) begin
         idx = $urandom_range(sb.active + 1);
         send_item(OP_FREE, chunk_addr(idx));
      end else if (r < 84) begin
         send_item(OP_FREE, addr);
      end else if (r < 88) begin
         send_item(OP_FREE, 32'd0);
      end else if (r < 91) begin
         send_item(OP_FREE, sb.base - 32'd1 - $urandom_range(255));
      end else if (r < 96) begin
         send_item(OP_UNUSED, addr);
      end else begin
         send_item(OP_FREE_ALL, addr);
      end
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
         1: begin src_idle_pct = 48; dst_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  dst_stall_pct = 48; end
         default: begin src_idle_pct = 30; dst_stall_pct = 30; end
      endcase
   endtask

   initial begin
      logic [31:0]  rbase;
      int unsigned  n;
      int           ph;
      sb = new;
      sb.power_on();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_POOL_BASE;
      csr_wdata  = '0;
      hold_go    = 1'b0;
      set_idling(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: base 4096, 64-byte chunks, 1024 chunks
      send_item(OP_ALLOC, 32'hFFFF_FFFF);
      send_item(OP_ALLOC, 32'd0);
      send_item(OP_FREE, 32'd0);
      send_item(OP_FREE, 32'd1);
      send_item(OP_FREE, 32'd4096 + 1023 * 64 + 63);   // low bits ignored
      send_item(OP_FREE, 32'd4096 + 1022 * 64);
      send_item(OP_FREE, 32'd4096 + 1022 * 64);        // double free
      send_item(OP_FREE, 32'd4096 + 1024 * 64);        // just past the pool
      send_item(OP_FREE, 32'hFFFF_FFFF);
      send_item(OP_UNUSED, 32'hFFFF_FFFF);
      send_item(OP_ALLOC, 32'd0);
      send_item(OP_ALLOC, 32'd0);
      send_item(OP_FREE_ALL, 32'd0);

      // zero count: empty pool, every free out of range
      configure(32'd1, 0, 0);
      send_item(OP_ALLOC, 32'd0);
      send_item(OP_FREE, 32'd1);

      // count saturates, top base, largest shift, addresses wrap
      configure(32'hFFFF_FFFF, 31, 2047);
      send_item(OP_ALLOC, 32'd0);
      send_item(OP_FREE, 32'h7FFF_FFFF);
      send_item(OP_FREE, 32'hFFFF_FFFF);
      send_item(OP_ALLOC, 32'd0);

      // single chunk
      configure(32'd4096, 16, 1);
      send_item(OP_ALLOC, 32'd0);
      send_item(OP_ALLOC, 32'd0);
      send_item(OP_FREE, 32'd4096 + 32'hFFFF);
      send_item(OP_FREE, 32'd4096 + 32'h1_0000);

      for (ph = 0; ph < 8; ph++) begin
         rbase = $urandom;
         if (rbase == 32'd0)
            rbase = 32'd1;
         case (ph)
            0: configure(32'h0000_1000, 6, 16);
            1: configure(32'd1, 0, 1);
            2: configure(32'hFFFF_FFFF, 16, 8);
            3: configure(rbase, $urandom_range(16), $urandom_range(32, 2));
            4: configure(32'h8000_0000, 31, 3);
            5: configure(rbase, 20, 2047);
            6: configure(rbase, $urandom_range(31), $urandom_range(64, 1));
            default: configure(32'h0040_0000, 12, 1024);
         endcase
         set_idling(ph % 4);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 0 && n == 40)
               hold_go = 1'b1;
            random_item();
         end
      end

      req_tvalid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
